// ----- hdl/etbd_pkg.sv -----
package etbd_pkg;

  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int BCOUNT_W = 7;
  localparam int IDX_W    = 6;
  localparam int SCORE_W  = 17;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // small queue between front end and back end
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_BITS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT  = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2640;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 7'd64;

  typedef struct packed {
    logic [TIME_W-1:0]   start_time;
    logic [PERIOD_W-1:0] bit_period;
    logic                invert_bits;
    logic [BCOUNT_W-1:0] byte_count;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    logic              first_edge;
    logic              end_of_data;
  } item_t;

  typedef struct packed {
    logic idle;
    logic pend_valid;
  } back_stat_t;

endpackage

// ----- hdl/etbd_if.sv -----
interface etbd_in_if;
  import etbd_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time;
  logic              first_edge;
  logic              end_of_data;

  modport source (output valid, edge_time, first_edge, end_of_data, input ready);
  modport sink   (input valid, edge_time, first_edge, end_of_data, output ready);
endinterface

interface etbd_out_if;
  import etbd_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic [IDX_W-1:0] byte_index;
  logic             run_last;
  logic             frame_done;

  modport source (output valid, data_byte, byte_index, run_last, frame_done, input ready);
  modport sink   (input valid, data_byte, byte_index, run_last, frame_done, output ready);
endinterface

// ----- hdl/etbd_front.sv -----
module etbd_front (
  input  logic           clk,
  input  logic           rst_n,
  etbd_in_if.sink        in_ch,
  input  logic           q_pop,
  output logic           q_valid,
  output etbd_pkg::item_t q_item
);
  import etbd_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   count_r, count_nxt;
  logic               push;
  logic               pop;
  item_t              in_item;

  assign in_ch.ready = (count_r != (Q_PTR_W+1)'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = mem[rd_ptr_r];

  always_comb begin
    in_item.edge_time   = in_ch.edge_time;
    in_item.first_edge  = in_ch.first_edge;
    in_item.end_of_data = in_ch.end_of_data;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- hdl/etbd_back.sv -----
module etbd_back #(
  parameter int MAX_BYTES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  etbd_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  etbd_pkg::item_t     q_item,
  output logic                q_pop,
  etbd_out_if.source          out_ch,
  output etbd_pkg::back_stat_t stat
);
  import etbd_pkg::*;

  localparam int BITS_W = $clog2(MAX_BYTES * 8 + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SEG    = 5'b00100,
    S_CLOSE  = 5'b01000,
    S_FINISH = 5'b10000
  } bstate_t;

  bstate_t             st_r, st_nxt;
  item_t               item_r, item_nxt;
  logic                flush_r, flush_nxt;
  logic                close_r, close_nxt;
  logic                level_r, level_nxt;
  logic                active_r, active_nxt;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [TIME_W-1:0]   window_end_r, window_end_nxt;
  logic [BITS_W-1:0]   bits_r, bits_nxt;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [TIME_W-1:0]   seg_tgt_r, seg_tgt_nxt;
  logic [SCORE_W:0]    seg_len_r, seg_len_nxt;
  logic                seg_upd_r, seg_upd_nxt;

  logic                pend_valid_r, pend_valid_nxt;
  logic [7:0]          pend_byte_r, pend_byte_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                pend_done_r, pend_done_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [IDX_W-1:0]    out_idx_r, out_idx_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_done_r, out_done_nxt;

  logic                out_free;
  logic [PERIOD_W-1:0] period_eff;
  logic [BITS_W-1:0]   total_bits;
  logic [BITS_W-1:0]   bits_inc;
  logic [TIME_W:0]     d_we, d_t, d_sel;
  logic                we_le_t;
  logic signed [SCORE_W+1:0] score_x, len_x, sum_x;
  logic signed [SCORE_W-1:0] sum_sat;
  logic [7:0]          shift_new;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign period_eff = (cfg.bit_period == '0) ? PERIOD_W'(1) : cfg.bit_period;
  assign total_bits = (cfg.byte_count == '0) ? BITS_W'(8) :
                      (cfg.byte_count > MAX_BYTES) ? BITS_W'(MAX_BYTES * 8) :
                      BITS_W'({cfg.byte_count, 3'b000});
  assign bits_inc   = bits_r + 1'b1;

  // both candidate segment lengths; the borrow bit says the target lies behind the last time
  assign d_we    = {1'b0, window_end_r} - {1'b0, last_time_r};
  assign d_t     = {1'b0, item_r.edge_time} - {1'b0, last_time_r};
  assign we_le_t = (window_end_r <= item_r.edge_time);

  assign score_x = {{2{score_r[SCORE_W-1]}}, score_r};
  assign len_x   = {1'b0, seg_len_r};
  assign sum_x   = level_r ? (score_x - len_x) : (score_x + len_x);

  always_comb begin
    if (sum_x > $signed(19'h0ffff)) begin
      sum_sat = 17'sh0ffff;
    end else if (sum_x < $signed(19'h70000)) begin
      sum_sat = 17'sh10000;
    end else begin
      sum_sat = sum_x[SCORE_W-1:0];
    end
  end

  assign shift_new = {shift_r[6:0], (score_r > 17'sd0)};

  always_comb begin
    st_nxt         = st_r;
    item_nxt       = item_r;
    flush_nxt      = flush_r;
    close_nxt      = close_r;
    level_nxt      = level_r;
    active_nxt     = active_r;
    last_time_nxt  = last_time_r;
    window_end_nxt = window_end_r;
    bits_nxt       = bits_r;
    score_nxt      = score_r;
    shift_nxt      = shift_r;
    seg_tgt_nxt    = seg_tgt_r;
    seg_len_nxt    = seg_len_r;
    seg_upd_nxt    = seg_upd_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    pend_idx_nxt   = pend_idx_r;
    pend_done_nxt  = pend_done_r;
    out_valid_nxt  = out_ch.ready ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_idx_nxt    = out_idx_r;
    out_last_nxt   = out_last_r;
    out_done_nxt   = out_done_r;
    q_pop          = 1'b0;
    d_sel          = d_t;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          flush_nxt = 1'b0;
          if (q_item.first_edge) begin
            level_nxt      = 1'b0;
            last_time_nxt  = cfg.start_time;
            window_end_nxt = cfg.start_time + {{(TIME_W-PERIOD_W){1'b0}}, period_eff};
            bits_nxt       = '0;
            score_nxt      = '0;
            shift_nxt      = '0;
            active_nxt     = 1'b1;
            flush_nxt      = 1'b1;
          end
          st_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (flush_r && !item_r.end_of_data) begin
          st_nxt = S_FINISH;
        end else if (!active_r || bits_r >= total_bits) begin
          active_nxt = 1'b0;
          if (flush_r) begin
            st_nxt = S_FINISH;
          end else begin
            flush_nxt = 1'b1;
          end
        end else begin
          // close the window if it ends at or before the edge or on a flush, else run up to the edge
          close_nxt   = flush_r || we_le_t;
          seg_tgt_nxt = close_nxt ? window_end_r : item_r.edge_time;
          d_sel       = close_nxt ? d_we : d_t;
          seg_upd_nxt = !d_sel[TIME_W] && (d_sel[TIME_W-1:0] != '0);
          seg_len_nxt = (d_sel[TIME_W-1:SCORE_W] != '0) ?
                        {1'b1, {SCORE_W{1'b0}}} : {1'b0, d_sel[SCORE_W-1:0]};
          st_nxt      = S_SEG;
        end
      end

      S_SEG: begin
        if (seg_upd_r) begin
          score_nxt     = sum_sat;
          last_time_nxt = seg_tgt_r;
        end
        if (close_r) begin
          st_nxt = S_CLOSE;
        end else begin
          level_nxt = !level_r;
          flush_nxt = 1'b1;
          st_nxt    = S_CHECK;
        end
      end

      S_CLOSE: begin
        // a finished byte needs the holding slot; stall if it cannot be freed
        if (!(bits_r[2:0] == 3'b111 && pend_valid_r && !out_free)) begin
          shift_nxt      = shift_new;
          score_nxt      = '0;
          window_end_nxt = window_end_r + {{(TIME_W-PERIOD_W){1'b0}}, period_eff};
          bits_nxt       = bits_inc;
          if (bits_inc >= total_bits) begin
            active_nxt = 1'b0;
          end
          if (bits_r[2:0] == 3'b111) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = pend_byte_r;
              out_idx_nxt   = pend_idx_r;
              out_last_nxt  = 1'b0;
              out_done_nxt  = pend_done_r;
            end
            pend_valid_nxt = 1'b1;
            pend_byte_nxt  = shift_new ^ {8{cfg.invert_bits}};
            pend_idx_nxt   = IDX_W'(bits_r >> 3);
            pend_done_nxt  = (bits_inc >= total_bits);
            shift_nxt      = '0;
          end
          st_nxt = S_CHECK;
        end
      end

      S_FINISH: begin
        if (!pend_valid_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = pend_byte_r;
          out_idx_nxt    = pend_idx_r;
          out_last_nxt   = 1'b1;
          out_done_nxt   = pend_done_r;
          pend_valid_nxt = 1'b0;
          st_nxt         = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      level_r      <= 1'b0;
      active_r     <= 1'b0;
      last_time_r  <= '0;
      window_end_r <= '0;
      bits_r       <= '0;
      score_r      <= '0;
      shift_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      flush_r      <= 1'b0;
      close_r      <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      level_r      <= level_nxt;
      active_r     <= active_nxt;
      last_time_r  <= last_time_nxt;
      window_end_r <= window_end_nxt;
      bits_r       <= bits_nxt;
      score_r      <= score_nxt;
      shift_r      <= shift_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      flush_r      <= flush_nxt;
      close_r      <= close_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    seg_tgt_r   <= seg_tgt_nxt;
    seg_len_r   <= seg_len_nxt;
    seg_upd_r   <= seg_upd_nxt;
    pend_byte_r <= pend_byte_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_done_r <= pend_done_nxt;
    out_byte_r  <= out_byte_nxt;
    out_idx_r   <= out_idx_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_byte  = out_byte_r;
  assign out_ch.byte_index = out_idx_r;
  assign out_ch.run_last   = out_last_r;
  assign out_ch.frame_done = out_done_r;

  always_comb begin
    stat.idle       = (st_r == S_IDLE);
    stat.pend_valid = pend_valid_r;
  end

endmodule

// ----- hdl/edge_timestamp_bit_demodulator_top.sv -----
// Edge timestamp NRZ bit demodulator.
// in_ch carries one word per signal edge: edge_time, first_edge, end_of_data,
// handshaked with valid/ready. A word with first_edge starts a capture, one
// with end_of_data flushes the open bit windows with the level held.
// out_ch carries one word per decoded byte: data_byte, byte_index, run_last
// (last byte caused by that input word) and frame_done (last byte of capture).
// cfg_we/cfg_index/cfg_wdata write start_time, bit_period, invert_bits and
// byte_count; write them only while the block is idle.
// Input words enter a 4-deep queue and are taken one at a time by the back
// end sequencer after the queue has registered them. The sequencer steps
// through one bit window at a time (compare, integrate, close). A finished
// byte waits in a holding slot until the word's next byte is finished or the
// word ends, and then moves to the output register that drives out_ch.
// Reset clears the queue, the decoder state and the output register and
// loads the register defaults; there is no clearing pass.
// When out_ch stalls, one byte waits in the output register and one in a
// holding slot; the sequencer then stops, and in_ch backs up once the
// queue is full.
module edge_timestamp_bit_demodulator_top #(
  parameter int MAX_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  etbd_in_if.sink                             in_ch,
  etbd_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [etbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [etbd_pkg::CFG_W-1:0]          cfg_wdata
);
  import etbd_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       q_valid;
  logic       q_pop;
  item_t      q_item;
  back_stat_t stat;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_TIME:  cfg_nxt.start_time  = cfg_wdata[TIME_W-1:0];
        CFG_BIT_PERIOD:  cfg_nxt.bit_period  = cfg_wdata[PERIOD_W-1:0];
        CFG_INVERT_BITS: cfg_nxt.invert_bits = cfg_wdata[0];
        CFG_BYTE_COUNT:  cfg_nxt.byte_count  = cfg_wdata[BCOUNT_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_time  <= '0;
      cfg_r.bit_period  <= PERIOD_RST;
      cfg_r.invert_bits <= 1'b0;
      cfg_r.byte_count  <= BCOUNT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  etbd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  etbd_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (stat)
  );

  // the final byte of a capture always ends its input word's results
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_done |-> out_ch.run_last)
    else $error("frame_done without run_last");

  // nothing may wait in the holding slot once the sequencer is back at idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    stat.idle |-> !stat.pend_valid)
    else $error("held byte lost at item end");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule
